@@ hdl/bridge_adc_reader_with_average_poly_core_assert.svh @@
// assertion macros for the bridge converter reader
// used by the top level only
`ifndef BRIDGE_ADC_READER_WITH_AVERAGE_POLY_CORE_ASSERT_SVH
`define BRIDGE_ADC_READER_WITH_AVERAGE_POLY_CORE_ASSERT_SVH
`define BAR_ASSERT_IMPL(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
`define BAR_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`endif

@@ hdl/bar_pkg.sv @@
// package for the bridge converter reader: payload types, register codes
// no dependencies
`default_nettype none
package bar_pkg;
   localparam int DATA_BITS_DEF = 24;
   localparam int MAX_AVERAGE_DEF = 32;
   localparam int ACC_W = 30;
   localparam int CNT_W = 6;
   localparam logic [1:0] REG_SAMPLES = 2'd0;
   localparam logic [1:0] REG_OFFSET = 2'd1;
   localparam logic [1:0] REG_LINEAR = 2'd2;
   localparam logic [1:0] REG_QUAD = 2'd3;

   typedef struct packed {
      logic start_req;
      logic dout_level;
   } req_type;

   typedef struct packed {
      logic sck_level;
      logic busy_res;
      logic result_valid;
      logic signed [23:0] raw_average;
      logic [23:0] frequency_q8;
      logic saturated;
   } rsp_type;

   typedef struct packed {
      logic clear_acc;
      logic clear_shift;
      logic shift_in;
      logic accumulate;
      logic start_calc;
   } cmd_type;

   typedef struct packed {
      logic last_bit;
      logic count_done;
      logic calc_done;
   } sts_type;
endpackage
`default_nettype wire

@@ hdl/bar_datapath.sv @@
// datapath: shift word, accumulator, serial divider and polynomial unit
// depends on bar_pkg
`default_nettype none
module bar_datapath #(
   parameter int DATA_BITS = bar_pkg::DATA_BITS_DEF
) (
   input  wire logic clock,
   input  wire logic reset,
   input  wire bar_pkg::cmd_type cmd,
   output bar_pkg::sts_type sts,
   input  wire logic dout_level,
   input  wire logic [5:0] samples_to_average,
   input  wire logic [23:0] offset_q8,
   input  wire logic [23:0] linear_coef,
   input  wire logic [15:0] quad_coef,
   output logic signed [23:0] avg_out,
   output logic [23:0] freq_out,
   output logic sat_out
);
   localparam int BC_W = $clog2(DATA_BITS + 2);
   localparam int CW = bar_pkg::CNT_W;
   localparam int AW = bar_pkg::ACC_W;

   typedef enum logic [4:0] {
      C_IDLE = 5'b00001,
      C_DIV  = 5'b00010,
      C_SQ   = 5'b00100,
      C_MUL  = 5'b01000,
      C_FIN  = 5'b10000
   } calc_type;

   logic [BC_W-1:0] bit_count_ff, bit_count_in;
   logic [DATA_BITS-1:0] shift_word_ff, shift_word_in;
   logic [CW-1:0] sample_count_ff, sample_count_in;
   logic signed [AW-1:0] acc_ff, acc_in;
   logic [CW-1:0] eff_count;

   // calc sequencer
   logic [4:0] step_ff, step_in;
   calc_type calc_ff, calc_in;
   logic [AW-1:0] quo_ff, quo_in, rem_ff, rem_in;
   logic neg_ff, neg_in;
   logic signed [23:0] avg_ff, avg_in;
   logic [23:0] freq_ff, freq_in;
   logic sat_ff, sat_in, done_ff, done_in;
   logic signed [48:0] lin_ff, lin_in;
   logic [47:0] sq_ff, sq_in;
   logic [63:0] q_ff, q_in;
   logic [23:0] mag;
   logic [AW:0] rem_sh;
   logic signed [AW-1:0] quo_s;
   logic [63:0] ub;
   logic signed [66:0] v;
   logic [63:0] r;

   always_comb begin
      if (samples_to_average == '0) eff_count = CW'(1);
      else if (32'(samples_to_average) > bar_pkg::MAX_AVERAGE_DEF)
         eff_count = CW'(bar_pkg::MAX_AVERAGE_DEF);
      else eff_count = samples_to_average;
   end

   always_comb begin
      bit_count_in = bit_count_ff;
      shift_word_in = shift_word_ff;
      sample_count_in = sample_count_ff;
      acc_in = acc_ff;
      if (cmd.clear_shift) begin
         bit_count_in = '0;
         shift_word_in = '0;
      end
      if (cmd.shift_in) begin
         if (32'(bit_count_ff) < DATA_BITS)
            shift_word_in = {shift_word_ff[DATA_BITS-2:0], dout_level};
         bit_count_in = bit_count_ff + BC_W'(1);
      end
      if (cmd.clear_acc) begin
         sample_count_in = '0;
         acc_in = '0;
      end
      if (cmd.accumulate) begin
         acc_in = acc_ff + AW'(signed'(shift_word_ff));
         sample_count_in = sample_count_ff + CW'(1);
      end
   end

   assign sts.last_bit = 32'(bit_count_ff) >= DATA_BITS + 1;
   assign sts.count_done = (sample_count_ff + CW'(1)) >= eff_count;
   assign sts.calc_done = done_ff;

   assign rem_sh = {rem_ff, quo_ff[AW-1]};
   assign quo_s = neg_ff ? -signed'(quo_ff) : signed'(quo_ff);
   assign mag = avg_ff[23] ? 24'(-avg_ff) : 24'(avg_ff);
   assign ub = 64'(lin_ff + (49'sd1 <<< 47));
   assign r = ({40'd0, ub[23:0]} << 16) + {24'd0, q_ff[39:0]};
   assign v = 67'(signed'({1'b0, offset_q8})) - (67'(signed'({1'b0, ub[63:24]}))
      - 67'sd8388608) - 67'(signed'({1'b0, q_ff[63:40]}))
      - 67'(signed'({1'b0, 24'((r + 64'hFF_FFFF_FFFF) >> 40)}));

   always_comb begin
      step_in = step_ff;
      calc_in = calc_ff;
      quo_in = quo_ff;
      rem_in = rem_ff;
      neg_in = neg_ff;
      avg_in = avg_ff;
      freq_in = freq_ff;
      sat_in = sat_ff;
      done_in = 1'b0;
      lin_in = lin_ff;
      sq_in = sq_ff;
      q_in = q_ff;
      unique case (calc_ff)
         C_IDLE: begin
            if (cmd.start_calc) begin
               // shift divider over the magnitude of the new sum
               neg_in = acc_in[AW-1];
               quo_in = acc_in[AW-1] ? AW'(-acc_in) : AW'(acc_in);
               rem_in = '0;
               step_in = 5'(AW - 1);
               calc_in = C_DIV;
            end
         end
         C_DIV: begin
            if (rem_sh >= {1'b0, AW'(sample_count_ff)}) begin
               rem_in = AW'(rem_sh - {1'b0, AW'(sample_count_ff)});
               quo_in = {quo_ff[AW-2:0], 1'b1};
            end else begin
               rem_in = rem_sh[AW-1:0];
               quo_in = {quo_ff[AW-2:0], 1'b0};
            end
            if (step_ff == '0) calc_in = C_SQ;
            else step_in = step_ff - 5'd1;
         end
         C_SQ: begin
            avg_in = 24'(quo_s);
            calc_in = C_MUL;
         end
         C_MUL: begin
            lin_in = signed'({1'b0, linear_coef}) * avg_ff;
            sq_in = mag * mag;
            calc_in = C_FIN;
         end
         C_FIN: begin
            if (step_ff == '0) begin
               q_in = 64'(sq_ff) * 64'(quad_coef);
               step_in = 5'd1;
            end else begin
               if (v < 0) begin
                  freq_in = '0;
                  sat_in = 1'b1;
               end else if (v > 67'sd16777215) begin
                  freq_in = 24'hFF_FFFF;
                  sat_in = 1'b1;
               end else begin
                  freq_in = v[23:0];
                  sat_in = 1'b0;
               end
               done_in = 1'b1;
               calc_in = C_IDLE;
            end
         end
         default: calc_in = C_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bit_count_ff <= '0;
         shift_word_ff <= '0;
         sample_count_ff <= '0;
         acc_ff <= '0;
         calc_ff <= C_IDLE;
         step_ff <= '0;
         done_ff <= 1'b0;
         avg_ff <= '0;
         freq_ff <= '0;
         sat_ff <= 1'b0;
      end else begin
         bit_count_ff <= bit_count_in;
         shift_word_ff <= shift_word_in;
         sample_count_ff <= sample_count_in;
         acc_ff <= acc_in;
         calc_ff <= calc_in;
         step_ff <= step_in;
         done_ff <= done_in;
         avg_ff <= avg_in;
         freq_ff <= freq_in;
         sat_ff <= sat_in;
      end
   end

   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      neg_ff <= neg_in;
      lin_ff <= lin_in;
      sq_ff <= sq_in;
      q_ff <= q_in;
   end

   assign avg_out = avg_ff;
   assign freq_out = freq_ff;
   assign sat_out = sat_ff;
endmodule
`default_nettype wire

@@ hdl/bar_control.sv @@
// tick sequencer: serial clock phases, word handshakes and result register
// depends on bar_pkg
`default_nettype none
module bar_control (
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic req_valid,
   output logic req_stall,
   input  wire bar_pkg::req_type req_word,
   output logic rsp_valid,
   input  wire logic rsp_stall,
   output bar_pkg::rsp_type rsp_word,
   output bar_pkg::cmd_type cmd,
   input  wire bar_pkg::sts_type sts,
   input  wire logic signed [23:0] avg_in_w,
   input  wire logic [23:0] freq_in_w,
   input  wire logic sat_in_w
);
   typedef enum logic [4:0] {
      S_IDLE = 5'b00001,
      S_WAIT = 5'b00010,
      S_HIGH = 5'b00100,
      S_LOW  = 5'b01000,
      S_CALC = 5'b10000
   } state_type;

   state_type state_ff, state_in;
   logic rsp_valid_ff, rsp_valid_in;
   bar_pkg::rsp_type rsp_ff, rsp_in;
   logic take;

   assign req_stall = rsp_valid_ff || (state_ff == S_CALC);
   assign take = req_valid && !req_stall;

   always_comb begin
      state_in = state_ff;
      cmd = '0;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_in = rsp_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (take) begin
               rsp_in.sck_level = 1'b0;
               rsp_in.result_valid = 1'b0;
               rsp_in.saturated = 1'b0;
               rsp_in.busy_res = req_word.start_req;
               rsp_valid_in = 1'b1;
               if (req_word.start_req) begin
                  cmd.clear_acc = 1'b1;
                  state_in = S_WAIT;
               end
            end
         end
         S_WAIT: begin
            if (take) begin
               rsp_in.sck_level = 1'b0;
               rsp_in.result_valid = 1'b0;
               rsp_in.saturated = 1'b0;
               rsp_in.busy_res = 1'b1;
               rsp_valid_in = 1'b1;
               if (!req_word.dout_level) begin
                  cmd.clear_shift = 1'b1;
                  state_in = S_HIGH;
               end
            end
         end
         S_HIGH: begin
            if (take) begin
               rsp_in.sck_level = 1'b1;
               rsp_in.result_valid = 1'b0;
               rsp_in.saturated = 1'b0;
               rsp_in.busy_res = 1'b1;
               rsp_valid_in = 1'b1;
               cmd.shift_in = 1'b1;
               state_in = S_LOW;
            end
         end
         S_LOW: begin
            if (take) begin
               rsp_in.sck_level = 1'b0;
               rsp_in.result_valid = 1'b0;
               rsp_in.saturated = 1'b0;
               rsp_in.busy_res = 1'b1;
               if (sts.last_bit) begin
                  cmd.accumulate = 1'b1;
                  if (sts.count_done) begin
                     // word goes out once the average and the calibrated frequency are known
                     cmd.start_calc = 1'b1;
                     state_in = S_CALC;
                  end else begin
                     rsp_valid_in = 1'b1;
                     state_in = S_WAIT;
                  end
               end else begin
                  rsp_valid_in = 1'b1;
                  state_in = S_HIGH;
               end
            end
         end
         S_CALC: begin
            if (sts.calc_done) begin
               rsp_in.busy_res = 1'b0;
               rsp_in.result_valid = 1'b1;
               rsp_in.raw_average = avg_in_w;
               rsp_in.frequency_q8 = freq_in_w;
               rsp_in.saturated = sat_in_w;
               rsp_valid_in = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         rsp_ff <= '0;
      end else begin
         state_ff <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word = rsp_ff;
endmodule
`default_nettype wire

@@ hdl/bridge_adc_reader_with_average_poly_core.sv @@
// averaging bridge converter reader with calibration polynomial
// each tick word yields a registered response word; the tick that ends a measurement
// also runs the 30-step serial divider, average, multiply and two finish stages
// a new tick word is stalled until the response register has drained and no calculation runs
// reset: synchronous, active high; all but the divider and polynomial work registers return to defaults
// depends on bar_pkg, bar_control, bar_datapath and the assertion header
`default_nettype none
`include "bridge_adc_reader_with_average_poly_core_assert.svh"
module bridge_adc_reader_with_average_poly_core #(
   parameter int DATA_BITS = bar_pkg::DATA_BITS_DEF
) (
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic req_valid,
   output logic req_stall,
   input  wire bar_pkg::req_type req_word,
   output logic rsp_valid,
   input  wire logic rsp_stall,
   output bar_pkg::rsp_type rsp_word,
   input  wire logic csr_valid,
   output logic csr_ready,
   input  wire logic [1:0] csr_index,
   input  wire logic [23:0] csr_data
);
   logic [5:0] samples_ff;
   logic [23:0] offset_ff, linear_ff;
   logic [15:0] quad_ff;
   bar_pkg::cmd_type cmd;
   bar_pkg::sts_type sts;
   logic signed [23:0] avg_w;
   logic [23:0] freq_w;
   logic sat_w;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         samples_ff <= 6'd10;
         offset_ff <= 24'd7197819;
         linear_ff <= 24'd6090264;
         quad_ff <= 16'd19703;
      end else if (csr_valid) begin
         unique case (csr_index)
            bar_pkg::REG_SAMPLES: samples_ff <= csr_data[5:0];
            bar_pkg::REG_OFFSET: offset_ff <= csr_data;
            bar_pkg::REG_LINEAR: linear_ff <= csr_data;
            bar_pkg::REG_QUAD: quad_ff <= csr_data[15:0];
            default: samples_ff <= samples_ff;
         endcase
      end
   end

   bar_control u_control (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_word(req_word),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_word(rsp_word),
      .cmd(cmd), .sts(sts),
      .avg_in_w(avg_w), .freq_in_w(freq_w), .sat_in_w(sat_w)
   );

   bar_datapath #(.DATA_BITS(DATA_BITS)) u_datapath (
      .clock(clock), .reset(reset), .cmd(cmd), .sts(sts),
      .dout_level(req_word.dout_level),
      .samples_to_average(samples_ff), .offset_q8(offset_ff),
      .linear_coef(linear_ff), .quad_coef(quad_ff),
      .avg_out(avg_w), .freq_out(freq_w), .sat_out(sat_w)
   );

   `BAR_ASSERT_IMPL(a_sat_only_valid, clock, reset,
      rsp_valid && !rsp_word.result_valid, !rsp_word.saturated, "saturated without result")
   `BAR_ASSERT_IMPL(a_result_not_busy, clock, reset,
      rsp_valid && rsp_word.result_valid, !rsp_word.busy_res, "busy on result word")
   `BAR_ASSERT_NEXT(a_one_cmd, clock, reset,
      1'b1, $countones({cmd.shift_in, cmd.accumulate, cmd.clear_shift}) <= 1, "command clash")
endmodule
`default_nettype wire

@@ bench/testbench.sv @@
// testbench for the averaging bridge converter reader with calibration polynomial
// drives tick words, predicts every response word and checks it field by field
// depends on bar_pkg and bridge_adc_reader_with_average_poly_core
`timescale 1ns / 100ps
module testbench;
   localparam int NBITS = 24;
   localparam int AVG_MAX = 32;
   localparam longint CYCLE_LIMIT = 4000000;

   typedef enum logic [1:0] {ST_IDLE, ST_WAIT, ST_HIGH, ST_LOW} tick_state_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   bar_pkg::req_type req_word = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   bar_pkg::rsp_type rsp_word;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [1:0] csr_index = bar_pkg::REG_SAMPLES;
   logic [23:0] csr_data = '0;

   bridge_adc_reader_with_average_poly_core dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_word(req_word),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_word(rsp_word),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_index(csr_index), .csr_data(csr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // predictor state
   logic [5:0] avg_setting;
   logic [23:0] offset_set, lin_set;
   logic [15:0] quad_set;
   tick_state_type tstate;
   logic [4:0] bits_taken;
   logic [23:0] shifter;
   logic [5:0] conv_count;
   longint acc_sum;
   logic signed [23:0] avg_hold;
   logic [23:0] freq_hold;

   bar_pkg::rsp_type expected_words[$];
   int errors = 0;
   longint cycles = 0;
   bit sender_idles = 1'b1;
   bit receiver_idles = 1'b1;
   int hold_off = 0;
   bit hold_request = 1'b0;
   bit hold_done = 1'b0;
   int long_left = 0;

   task automatic report(input string what, input longint got, input longint want);
      errors++;
      $display("mismatch %s: got %0d expected %0d at cycle %0d", what, got, want, cycles);
   endtask

   function automatic logic [23:0] calibrate(input longint raw, output logic clipped);
      longint lin, lh, v;
      longint unsigned ub, ll, mag, q, qh, ql, r, c;
      lin = longint'(lin_set) * raw;
      ub = longint'(lin + (64'sd1 <<< 47));
      lh = longint'(ub >> 24) - (64'sd1 <<< 23);
      ll = ub & 64'hFFFFFF;
      mag = raw < 0 ? longint'(-raw) : longint'(raw);
      q = longint'(quad_set) * mag * mag;
      qh = q >> 40;
      ql = q & ((64'd1 << 40) - 1);
      r = (ll << 16) + ql;
      c = (r + (64'd1 << 40) - 1) >> 40;
      v = longint'(offset_set) - lh - longint'(qh) - longint'(c);
      clipped = 1'b0;
      if (v < 0) begin
         clipped = 1'b1;
         return 24'd0;
      end
      if (v > 64'shFFFFFF) begin
         clipped = 1'b1;
         return 24'hFFFFFF;
      end
      return v[23:0];
   endfunction

   function automatic bar_pkg::rsp_type predict_tick(input bar_pkg::req_type w);
      bar_pkg::rsp_type o;
      longint eff;
      logic clipped;
      o = '0;
      case (tstate)
         ST_IDLE: begin
            if (w.start_req) begin
               conv_count = 6'd0;
               acc_sum = 0;
               tstate = ST_WAIT;
            end
         end
         ST_WAIT: begin
            if (!w.dout_level) begin
               shifter = 24'd0;
               bits_taken = 5'd0;
               tstate = ST_HIGH;
            end
         end
         ST_HIGH: begin
            o.sck_level = 1'b1;
            if (bits_taken < NBITS) shifter = {shifter[22:0], w.dout_level};
            bits_taken = bits_taken + 5'd1;
            tstate = ST_LOW;
         end
         default: begin
            if (bits_taken >= NBITS + 1) begin
               acc_sum += longint'(signed'(shifter));
               conv_count = conv_count + 6'd1;
               eff = avg_setting == 0 ? 1 : (avg_setting > AVG_MAX ? AVG_MAX : avg_setting);
               if (conv_count >= eff) begin
                  avg_hold = 24'(acc_sum / longint'(conv_count));
                  freq_hold = calibrate(longint'(avg_hold), clipped);
                  o.saturated = clipped;
                  o.result_valid = 1'b1;
                  tstate = ST_IDLE;
               end else begin
                  tstate = ST_WAIT;
               end
            end else begin
               tstate = ST_HIGH;
            end
         end
      endcase
      o.busy_res = tstate != ST_IDLE;
      o.raw_average = avg_hold;
      o.frequency_q8 = freq_hold;
      return o;
   endfunction

   task automatic send_tick(input logic start, input logic dout);
      bar_pkg::req_type w;
      if (sender_idles && $urandom_range(0, 9) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 19)) @(posedge clock);
      end
      w.start_req = start;
      w.dout_level = dout;
      req_valid <= 1'b1;
      req_word <= w;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      expected_words.push_back(predict_tick(w));
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (expected_words.size() != 0) @(posedge clock);
      repeat (60) @(posedge clock);
   endtask

   task automatic write_reg(input logic [1:0] idx, input logic [23:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= val;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      case (idx)
         bar_pkg::REG_SAMPLES: avg_setting = val[5:0];
         bar_pkg::REG_OFFSET: offset_set = val;
         bar_pkg::REG_LINEAR: lin_set = val;
         default: quad_set = val[15:0];
      endcase
      @(posedge clock);
   endtask

   // one whole conversion: wait ticks, then 25 pulses carrying the data word
   task automatic send_conversion(input logic [23:0] value, input bit noisy);
      int waits;
      waits = noisy ? $urandom_range(0, 3) : 0;
      repeat (waits) send_tick(1'($urandom_range(0, 1)), 1'b1);
      send_tick(1'($urandom_range(0, 1)), 1'b0);
      for (int i = 0; i < NBITS + 1; i++) begin
         send_tick(1'($urandom_range(0, 1)),
                   i < NBITS ? value[NBITS - 1 - i] : 1'($urandom_range(0, 1)));
         send_tick(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
      end
   endtask

   task automatic measure(input int count, input logic [23:0] value, input bit rnd);
      send_tick(1'b1, 1'($urandom_range(0, 1)));
      for (int i = 0; i < count; i++) send_conversion(rnd ? 24'($urandom) : value, rnd);
   endtask

   task automatic test_idle_noise();
      for (int i = 0; i < 6; i++) send_tick(1'b0, 1'($urandom_range(0, 1)));
   endtask

   task automatic test_extremes();
      drain();
      write_reg(bar_pkg::REG_SAMPLES, 24'd1);
      measure(1, 24'h7FFFFF, 1'b0);
      measure(1, 24'h800000, 1'b0);
      measure(1, 24'hFFFFFF, 1'b0);
      drain();
      write_reg(bar_pkg::REG_SAMPLES, 24'd0);
      write_reg(bar_pkg::REG_OFFSET, 24'hFFFFFF);
      write_reg(bar_pkg::REG_LINEAR, 24'hFFFFFF);
      write_reg(bar_pkg::REG_QUAD, 24'hFFFF);
      measure(1, 24'h800000, 1'b0);
      measure(1, 24'h7FFFFF, 1'b0);
      drain();
   endtask

   task automatic test_averaging();
      write_reg(bar_pkg::REG_SAMPLES, 24'd3);
      write_reg(bar_pkg::REG_OFFSET, 24'd7197819);
      write_reg(bar_pkg::REG_LINEAR, 24'd6090264);
      write_reg(bar_pkg::REG_QUAD, 24'd19703);
      measure(3, 24'hFFFFFE, 1'b1);
      drain();
      // count above the maximum, then lowered while the measurement runs
      write_reg(bar_pkg::REG_SAMPLES, 24'd63);
      measure(1, 24'd0, 1'b1);
      drain();
      write_reg(bar_pkg::REG_SAMPLES, 24'd1);
      send_conversion(24'($urandom), 1'b1);
      drain();
   endtask

   task automatic test_pressure();
      hold_request = 1'b1;
      measure(1, 24'h654321, 1'b1);
      drain();
   endtask

   task automatic test_random(input int nmeas);
      for (int m = 0; m < nmeas; m++) begin
         if (m % 6 == 0) begin
            drain();
            write_reg(bar_pkg::REG_SAMPLES, 24'($urandom_range(0, 3) == 0
                                                ? $urandom_range(0, 63)
                                                : $urandom_range(1, 2)));
            write_reg(bar_pkg::REG_OFFSET, 24'($urandom));
            write_reg(bar_pkg::REG_LINEAR, 24'($urandom));
            write_reg(bar_pkg::REG_QUAD, 24'($urandom));
         end
         if ($urandom_range(0, 4) == 0) test_idle_noise();
         measure(avg_setting == 0 ? 1 : (avg_setting > 2 ? 2 : avg_setting), 24'd0, 1'b1);
         // start while busy and stray ticks after an aborted run
         if (avg_setting > 2) begin
            drain();
            write_reg(bar_pkg::REG_SAMPLES, 24'($urandom_range(1, 2)));
         end
      end
   endtask

   always @(posedge clock) begin
      bar_pkg::rsp_type want;
      cycles <= cycles + 1;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_words.size() == 0) begin
            report("unexpected word", rsp_word, 0);
         end else begin
            want = expected_words.pop_front();
            if (rsp_word.sck_level !== want.sck_level)
               report("sck_level", rsp_word.sck_level, want.sck_level);
            if (rsp_word.busy_res !== want.busy_res)
               report("busy_res", rsp_word.busy_res, want.busy_res);
            if (rsp_word.result_valid !== want.result_valid)
               report("result_valid", rsp_word.result_valid, want.result_valid);
            if (rsp_word.raw_average !== want.raw_average)
               report("raw_average", rsp_word.raw_average, want.raw_average);
            if (rsp_word.frequency_q8 !== want.frequency_q8)
               report("frequency_q8", rsp_word.frequency_q8, want.frequency_q8);
            if (rsp_word.saturated !== want.saturated)
               report("saturated", rsp_word.saturated, want.saturated);
         end
      end
   end

   // one long receiver hold-off while the sender keeps offering words
   always @(posedge clock) begin
      if (long_left > 0) begin
         long_left <= long_left - 1;
      end else if (hold_request && !hold_done) begin
         long_left <= 400;
         hold_done <= 1'b1;
      end
   end

   // receiver stalls: random bursts, the long hold-off, none near the end
   always @(posedge clock) begin
      if (long_left > 0) begin
         rsp_stall <= 1'b1;
      end else if (hold_off > 0) begin
         hold_off <= hold_off - 1;
         rsp_stall <= 1'b1;
      end else if (receiver_idles && $urandom_range(0, 12) == 0) begin
         hold_off <= $urandom_range(1, 19) - 1;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   always @(posedge clock) begin
      if (cycles > CYCLE_LIMIT) begin
         $display("FAILURE");
         $finish;
      end
   end

   initial begin
      avg_setting = 6'd10;
      offset_set = 24'd7197819;
      lin_set = 24'd6090264;
      quad_set = 16'd19703;
      tstate = ST_IDLE;
      bits_taken = 5'd0;
      shifter = 24'd0;
      conv_count = 6'd0;
      acc_sum = 0;
      avg_hold = 24'sd0;
      freq_hold = 24'd0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_idle_noise();
      test_extremes();
      test_averaging();
      test_pressure();
      test_random(1);
      sender_idles = 1'b0;
      receiver_idles = 1'b0;
      test_random(1);
      drain();
      if (errors == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end
endmodule

@@ files.f @@
+incdir+hdl
hdl/bar_pkg.sv
hdl/bar_datapath.sv
hdl/bar_control.sv
hdl/bridge_adc_reader_with_average_poly_core.sv
bench/testbench.sv
